// ===== hw/rtl/dqua_pkg.sv =====
package dqua_pkg;

  // Default table geometry
  localparam int PORT_COUNT_DEF     = 64;
  localparam int NUM_PRIORITIES_DEF = 8;
  localparam int NUM_MEM_GROUPS_DEF = 8;

  // Field widths
  localparam int REQ_W  = 3;
  localparam int ECN_W  = 2;
  localparam int PORT_W = 6;
  localparam int PRIO_W = 3;
  localparam int TAG_W  = 32;
  localparam int IDX_W  = 6;
  localparam int UTIL_W = 8;
  localparam int ACT_W  = 2;
  localparam int GRP_W  = 3;
  localparam int MAP_W  = 24;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [UTIL_W-1:0] THRESHOLD_RESET = 8'd124;
  localparam logic [MAP_W-1:0]  GROUP_MAP_RESET = '0;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_PACKET     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_MEM_GROUP  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PORT_GROUP = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PRIO_QUEUE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_L4S_QUEUE  = 3'd4;

  // Actions
  localparam logic [ACT_W-1:0] ACT_CLASSIC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_L4S     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DROP    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GROUP_MAP = 8'd1;

  // Packet context held between table lookup and decision
  typedef struct packed {
    logic              l4s;
    logic              port_ok;
    logic              pq_ok;
    logic [UTIL_W-1:0] grp_util;
    logic [PORT_W-1:0] port;
    logic [TAG_W-1:0]  tag;
  } dqua_s1_t;

endpackage

// ===== hw/rtl/dqua_ram.sv =====
module dqua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dqua_lookup.sv =====
module dqua_lookup import dqua_pkg::*; #(
  parameter int PORT_COUNT     = PORT_COUNT_DEF,
  parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
  parameter int NUM_MEM_GROUPS = NUM_MEM_GROUPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [ECN_W-1:0]  ecn_bits,
  input  logic [PORT_W-1:0] pkt_port,
  input  logic [PRIO_W-1:0] prio,
  input  logic [TAG_W-1:0]  packet_tag,
  input  logic [IDX_W-1:0]  entry_idx,
  input  logic [UTIL_W-1:0] new_utilization,
  input  logic [MAP_W-1:0]  group_map,
  input  logic              s1_take,
  output logic              s1_valid,
  output dqua_s1_t          s1,
  output logic [UTIL_W-1:0] pg_util,
  output logic [UTIL_W-1:0] pq_util,
  output logic [UTIL_W-1:0] ll_util
);

  localparam int PORT_AW  = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int PQ_DEPTH = PORT_COUNT * NUM_PRIORITIES;
  localparam int PQ_AW    = (PQ_DEPTH > 1) ? $clog2(PQ_DEPTH) : 1;
  // Only groups 0..7 are reachable through the 3-bit map entries
  localparam int GRP_N     = (NUM_MEM_GROUPS < 8) ? NUM_MEM_GROUPS : 8;
  localparam int GRP_AW    = (GRP_N > 1) ? $clog2(GRP_N) : 1;
  localparam int GRP_SLOTS = 1 << GRP_AW;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } st_t;

  st_t               st_r, st_nxt;
  logic [PQ_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              clearing;
  logic              clr_last;
  logic              in_acc, pkt_acc;
  logic [31:0]       port32, prio32, idx32, pq32, clr32;
  logic              port_ok, prio_ok, idx_port_ok, idx_grp_ok;
  logic [GRP_W-1:0]  grp;
  logic              grp_ok;
  logic [UTIL_W-1:0] grp_val;
  logic [UTIL_W-1:0] grp_util_r [GRP_SLOTS];
  logic              s1_valid_r, s1_valid_nxt;
  dqua_s1_t          s1_r;

  logic               pg_we, pq_we, ll_we;
  logic [PORT_AW-1:0] port_waddr, port_raddr;
  logic [PQ_AW-1:0]   pq_waddr, pq_raddr;
  logic [UTIL_W-1:0]  wdata;

  assign clearing = (st_r == ST_CLEAR);
  assign clr_last = (clr_cnt_r == PQ_AW'(PQ_DEPTH - 1));
  assign clr32    = 32'(clr_cnt_r);

  always_comb begin
    st_nxt      = st_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (st_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_cnt_nxt = clr_cnt_r;
      end
      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      st_r      <= st_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign in_tready = !clearing && (!s1_valid_r || s1_take);
  assign in_acc    = in_tvalid && in_tready;
  assign pkt_acc   = in_acc && (req_type == REQ_PACKET);

  assign port32      = 32'(pkt_port);
  assign prio32      = 32'(prio);
  assign idx32       = 32'(entry_idx);
  assign pq32        = port32 * 32'(NUM_PRIORITIES) + prio32;
  assign port_ok     = port32 < 32'(PORT_COUNT);
  assign prio_ok     = prio32 < 32'(NUM_PRIORITIES);
  assign idx_port_ok = idx32 < 32'(PORT_COUNT);
  assign idx_grp_ok  = idx32 < 32'(GRP_N);

  assign grp     = group_map[prio*GRP_W +: GRP_W];
  assign grp_ok  = 32'(grp) < 32'(NUM_MEM_GROUPS);
  assign grp_val = grp_ok ? grp_util_r[grp[GRP_AW-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GRP_SLOTS; i++) begin
        grp_util_r[i] <= '0;
      end
    end else if (in_acc && (req_type == REQ_MEM_GROUP) && idx_grp_ok) begin
      grp_util_r[entry_idx[GRP_AW-1:0]] <= new_utilization;
    end
  end

  // Reset clears the tables by sweeping every address once
  assign wdata      = clearing ? '0 : new_utilization;
  assign port_waddr = clearing ? clr32[PORT_AW-1:0] : idx32[PORT_AW-1:0];
  assign pq_waddr   = clearing ? clr_cnt_r : pq32[PQ_AW-1:0];
  assign port_raddr = port32[PORT_AW-1:0];
  assign pq_raddr   = pq32[PQ_AW-1:0];

  assign pg_we = clearing ? (clr32 < 32'(PORT_COUNT))
                          : (in_acc && (req_type == REQ_PORT_GROUP) && idx_port_ok);
  assign ll_we = clearing ? (clr32 < 32'(PORT_COUNT))
                          : (in_acc && (req_type == REQ_L4S_QUEUE) && idx_port_ok);
  assign pq_we = clearing
              || (in_acc && (req_type == REQ_PRIO_QUEUE) && port_ok && prio_ok);

  dqua_ram #(.WIDTH(UTIL_W), .DEPTH(PORT_COUNT)) u_pg_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (port_waddr),
    .wdata (wdata),
    .re    (pkt_acc),
    .raddr (port_raddr),
    .rdata (pg_util)
  );

  dqua_ram #(.WIDTH(UTIL_W), .DEPTH(PQ_DEPTH)) u_pq_ram (
    .clk   (clk),
    .we    (pq_we),
    .waddr (pq_waddr),
    .wdata (wdata),
    .re    (pkt_acc),
    .raddr (pq_raddr),
    .rdata (pq_util)
  );

  dqua_ram #(.WIDTH(UTIL_W), .DEPTH(PORT_COUNT)) u_ll_ram (
    .clk   (clk),
    .we    (ll_we),
    .waddr (port_waddr),
    .wdata (wdata),
    .re    (pkt_acc),
    .raddr (port_raddr),
    .rdata (ll_util)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (pkt_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_acc) begin
      s1_r.l4s      <= ecn_bits[0];
      s1_r.port_ok  <= port_ok;
      s1_r.pq_ok    <= port_ok && prio_ok;
      s1_r.grp_util <= grp_val;
      s1_r.port     <= pkt_port;
      s1_r.tag      <= packet_tag;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

`ifndef SYNTHESIS
  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_acc)
    else $error("item taken during table clear");

  a_s1_held_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_take |=> s1_valid_r && $stable(s1_r.tag))
    else $error("pending packet lost before decision");

  a_clear_reaches_run: assert property (@(posedge clk) disable iff (!rst_n)
    clearing && clr_last |=> (st_r == ST_RUN))
    else $error("clear pass did not finish");
`endif

endmodule

// ===== hw/rtl/dqua_decide.sv =====
module dqua_decide import dqua_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [UTIL_W-1:0] threshold,
  input  logic              s1_valid,
  input  dqua_s1_t          s1,
  input  logic [UTIL_W-1:0] pg_util,
  input  logic [UTIL_W-1:0] pq_util,
  input  logic [UTIL_W-1:0] ll_util,
  output logic              s1_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ACT_W-1:0]  out_action,
  output logic [PORT_W-1:0] out_port,
  output logic [TAG_W-1:0]  out_tag,
  output logic [UTIL_W-1:0] out_util
);

  logic [UTIL_W-1:0] pg_val, pq_val, ll_val, cls_a, cls_util, util;
  logic [ACT_W-1:0]  act;
  logic              out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]  out_action_r;
  logic [PORT_W-1:0] out_port_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [UTIL_W-1:0] out_util_r;

  // A table entry outside its table counts as zero utilization
  assign pg_val   = s1.port_ok ? pg_util : '0;
  assign pq_val   = s1.pq_ok ? pq_util : '0;
  assign ll_val   = s1.port_ok ? ll_util : '0;
  assign cls_a    = (pg_val > s1.grp_util) ? pg_val : s1.grp_util;
  assign cls_util = (pq_val > cls_a) ? pq_val : cls_a;
  assign util     = s1.l4s ? ll_val : cls_util;

  always_comb begin
    if (util < threshold) begin
      act = s1.l4s ? ACT_L4S : ACT_CLASSIC;
    end else begin
      act = ACT_DROP;
    end
  end

  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_action_r <= act;
      out_port_r   <= s1.port;
      out_tag_r    <= s1.tag;
      out_util_r   <= util;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_port   = out_port_r;
  assign out_tag    = out_tag_r;
  assign out_util   = out_util_r;

`ifndef SYNTHESIS
  a_drop_matches_threshold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_action_r == ACT_DROP) == (out_util_r >= threshold)))
    else $error("action disagrees with threshold");

  a_stalled_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_tag_r)
                                  && $stable(out_action_r))
    else $error("stalled item overwritten");

  a_action_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_action_r == ACT_CLASSIC || out_action_r == ACT_L4S
                     || out_action_r == ACT_DROP))
    else $error("illegal action code");
`endif

endmodule

// ===== hw/rtl/dualq_utilization_admission_core.sv =====
// Dual-queue admission check with utilization tables.
//
// Input channel (in_*): one item per handshake. in_tuser carries the request
// kind; a packet item yields one result, table update items yield none.
// Result channel (out_*): action in out_tuser, port/tag/utilization in
// out_tdata. Configuration channel (cfg_*): threshold and priority-to-group
// map writes, always ready, to be written only while the block is idle.
//
// Pipeline: an accepted packet passes the table read register, then the
// result register that drives out_*. One item is taken per cycle unless the
// result side stalls; updates are written at the edge they are accepted.
// Reset: the port-priority, port-group and L4S tables are swept to zero, one
// address per cycle, over all PORT_COUNT*NUM_PRIORITIES port-priority
// addresses (512 by default); in_tready stays low during the sweep. Memory
// groups, threshold (124) and the group map (0) are cleared at once.
//
// Stall: a held result keeps its data; one more packet waits in the read
// stage, and in_tready drops until the result side moves again.
module dualq_utilization_admission_core import dqua_pkg::*; #(
  parameter int PORT_COUNT     = PORT_COUNT_DEF,
  parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
  parameter int NUM_MEM_GROUPS = NUM_MEM_GROUPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // ecn_bits[1:0], pkt_port[7:2], prio[10:8], packet_tag[42:11],
  // entry_idx[48:43], new_utilization[56:49], zero[63:57]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[2:0]
  input  logic [REQ_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_port[5:0], out_tag[37:6], checked_utilization[45:38], zero[47:46]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // action[1:0]
  output logic [ACT_W-1:0]      out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [UTIL_W-1:0] thr_r, thr_nxt;
  logic [MAP_W-1:0]  map_r, map_nxt;
  logic              s1_valid, s1_take;
  dqua_s1_t          s1;
  logic [UTIL_W-1:0] pg_util, pq_util, ll_util;
  logic [ACT_W-1:0]  res_action;
  logic [PORT_W-1:0] res_port;
  logic [TAG_W-1:0]  res_tag;
  logic [UTIL_W-1:0] res_util;

  assign cfg_ready = 1'b1;

  always_comb begin
    thr_nxt = thr_r;
    map_nxt = map_r;
    if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_THRESHOLD: thr_nxt = cfg_data[UTIL_W-1:0];
        CFG_GROUP_MAP: map_nxt = cfg_data[MAP_W-1:0];
        default: begin
          thr_nxt = thr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
      map_r <= GROUP_MAP_RESET;
    end else begin
      thr_r <= thr_nxt;
      map_r <= map_nxt;
    end
  end

  dqua_lookup #(
    .PORT_COUNT     (PORT_COUNT),
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .NUM_MEM_GROUPS (NUM_MEM_GROUPS)
  ) u_lookup (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .req_type        (in_tuser),
    .ecn_bits        (in_tdata[1:0]),
    .pkt_port        (in_tdata[7:2]),
    .prio            (in_tdata[10:8]),
    .packet_tag      (in_tdata[42:11]),
    .entry_idx       (in_tdata[48:43]),
    .new_utilization (in_tdata[56:49]),
    .group_map       (map_r),
    .s1_take         (s1_take),
    .s1_valid        (s1_valid),
    .s1              (s1),
    .pg_util         (pg_util),
    .pq_util         (pq_util),
    .ll_util         (ll_util)
  );

  dqua_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .threshold  (thr_r),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .pg_util    (pg_util),
    .pq_util    (pq_util),
    .ll_util    (ll_util),
    .s1_take    (s1_take),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_action (res_action),
    .out_port   (res_port),
    .out_tag    (res_tag),
    .out_util   (res_util)
  );

  assign out_tuser = res_action;
  assign out_tdata = {2'b00, res_util, res_tag, res_port};

endmodule

// ===== sim/tb_dualq_utilization_admission_core.sv =====
`timescale 1ns / 100ps

module tb_dualq_utilization_admission_core;
  import dqua_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_PHASES   = 6;
  localparam int NUM_DIRECTED = 25;

  // request kinds the block has no use for
  localparam logic [REQ_W-1:0] REQ_RSVD_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;

  localparam int IDX_MAX = (1 << IDX_W) - 1;
  localparam int UTIL_MAX = (1 << UTIL_W) - 1;
  localparam int PQ_IDX_W = $clog2(PORT_COUNT_DEF * NUM_PRIORITIES_DEF);

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [ECN_W-1:0]  ecn;
    logic [PORT_W-1:0] port;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic [IDX_W-1:0]  idx;
    logic [UTIL_W-1:0] val;
  } adm_req_t;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [PORT_W-1:0] port;
    logic [TAG_W-1:0]  tag;
    logic [UTIL_W-1:0] util;
  } verdict_t;

  // typed = 1: act/util below are the expected result, else the predictor's
  typedef struct packed {
    adm_req_t          it;
    logic              typed;
    logic [ACT_W-1:0]  act;
    logic [UTIL_W-1:0] util;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]      in_tuser = REQ_PACKET;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [ACT_W-1:0]      out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dualq_utilization_admission_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the admission tables and registers
  logic [UTIL_W-1:0] grp_util_m   [NUM_MEM_GROUPS_DEF];
  logic [UTIL_W-1:0] port_grp_m   [PORT_COUNT_DEF];
  logic [UTIL_W-1:0] prio_q_m     [PORT_COUNT_DEF*NUM_PRIORITIES_DEF];
  logic [UTIL_W-1:0] l4s_util_m   [PORT_COUNT_DEF];
  logic [UTIL_W-1:0] thr_m = THRESHOLD_RESET;
  logic [MAP_W-1:0]  gmap_m = GROUP_MAP_RESET;

  verdict_t pending_verdicts[$];
  int       errors = 0;
  int       cycles = 0;
  int       snd_idle_pct = 0;
  int       rcv_idle_pct = 0;
  bit       hold_req = 1'b0;
  int       hold_left = 0;

  dir_row_t dir_tbl [NUM_DIRECTED] = '{
    '{'{REQ_PACKET, 2'd0, 6'd0, 3'd0, 32'h0, 6'd0, 8'd0}, 1'b1, ACT_CLASSIC, 8'd0},
    '{'{REQ_PACKET, 2'd1, 6'd63, 3'd7, 32'hFFFF_FFFF, 6'd63, 8'd255}, 1'b1, ACT_L4S, 8'd0},
    '{'{REQ_PACKET, 2'd3, 6'd21, 3'd5, 32'h5A5A_5A5A, 6'd21, 8'd85}, 1'b1, ACT_L4S, 8'd0},
    '{'{REQ_PACKET, 2'd2, 6'd42, 3'd2, 32'hA5A5_A5A5, 6'd42, 8'd170}, 1'b1, ACT_CLASSIC, 8'd0},
    '{'{REQ_MEM_GROUP, 2'd0, 6'd0, 3'd0, 32'h0, 6'd0, 8'd255}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_PACKET, 2'd0, 6'd10, 3'd4, 32'h1, 6'd0, 8'd0}, 1'b1, ACT_DROP, 8'd255},
    '{'{REQ_PACKET, 2'd1, 6'd10, 3'd4, 32'h2, 6'd0, 8'd0}, 1'b1, ACT_L4S, 8'd0},
    '{'{REQ_MEM_GROUP, 2'd0, 6'd0, 3'd0, 32'h0, 6'd0, 8'd0}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_MEM_GROUP, 2'd0, 6'd0, 3'd0, 32'h0, 6'd63, 8'd200}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_MEM_GROUP, 2'd0, 6'd0, 3'd0, 32'h0, 6'd8, 8'd200}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_PACKET, 2'd0, 6'd10, 3'd4, 32'h3, 6'd0, 8'd0}, 1'b1, ACT_CLASSIC, 8'd0},
    '{'{REQ_PORT_GROUP, 2'd0, 6'd0, 3'd0, 32'h0, 6'd63, 8'd123}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_PRIO_QUEUE, 2'd0, 6'd63, 3'd7, 32'h0, 6'd0, 8'd124}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_PACKET, 2'd0, 6'd63, 3'd6, 32'h4, 6'd0, 8'd0}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_PACKET, 2'd2, 6'd63, 3'd7, 32'h5, 6'd0, 8'd0}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_L4S_QUEUE, 2'd0, 6'd0, 3'd0, 32'h0, 6'd1, 8'd123}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_PACKET, 2'd1, 6'd1, 3'd0, 32'h6, 6'd0, 8'd0}, 1'b1, ACT_L4S, 8'd123},
    '{'{REQ_L4S_QUEUE, 2'd0, 6'd0, 3'd0, 32'h0, 6'd1, 8'd124}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_PACKET, 2'd3, 6'd1, 3'd0, 32'h7, 6'd0, 8'd0}, 1'b1, ACT_DROP, 8'd124},
    '{'{REQ_RSVD_5, 2'd1, 6'd1, 3'd0, 32'h8, 6'd1, 8'd0}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_RSVD_6, 2'd0, 6'd0, 3'd0, 32'h9, 6'd0, 8'd255}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_RSVD_7, 2'd3, 6'd1, 3'd7, 32'hA, 6'd1, 8'd0}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_PACKET, 2'd1, 6'd1, 3'd0, 32'hB, 6'd0, 8'd0}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_PORT_GROUP, 2'd0, 6'd0, 3'd0, 32'h0, 6'd0, 8'd255}, 1'b0, ACT_CLASSIC, 8'd0},
    '{'{REQ_PACKET, 2'd0, 6'd0, 3'd0, 32'hC, 6'd0, 8'd0}, 1'b1, ACT_DROP, 8'd255}
  };

  // returns 1 when the item yields a verdict; counted = item had an effect
  function automatic bit admit_model(input adm_req_t it, output verdict_t v,
                                     output bit counted);
    logic [UTIL_W-1:0]   u;
    logic [GRP_W-1:0]    grp;
    logic [PQ_IDX_W-1:0] q;
    u = '0;
    v = '0;
    counted = 1'b0;
    q = PQ_IDX_W'(int'(it.port) * NUM_PRIORITIES_DEF + int'(it.prio));
    case (it.req)
      REQ_PACKET: begin
        counted = 1'b1;
        if (it.ecn[0]) begin
          if (it.port < PORT_COUNT_DEF) u = l4s_util_m[it.port];
        end else begin
          grp = gmap_m[it.prio*GRP_W +: GRP_W];
          if (grp < NUM_MEM_GROUPS_DEF) u = grp_util_m[grp];
          if (it.port < PORT_COUNT_DEF && port_grp_m[it.port] > u) u = port_grp_m[it.port];
          if (it.port < PORT_COUNT_DEF && it.prio < NUM_PRIORITIES_DEF) begin
            if (prio_q_m[q] > u) u = prio_q_m[q];
          end
        end
        v.act  = (u < thr_m) ? (it.ecn[0] ? ACT_L4S : ACT_CLASSIC) : ACT_DROP;
        v.port = it.port;
        v.tag  = it.tag;
        v.util = u;
        return 1'b1;
      end
      REQ_MEM_GROUP: begin
        if (it.idx < NUM_MEM_GROUPS_DEF) begin
          grp_util_m[it.idx[GRP_W-1:0]] = it.val;
          counted = 1'b1;
        end
      end
      REQ_PORT_GROUP: begin
        if (it.idx < PORT_COUNT_DEF) begin
          port_grp_m[it.idx] = it.val;
          counted = 1'b1;
        end
      end
      REQ_PRIO_QUEUE: begin
        if (it.port < PORT_COUNT_DEF && it.prio < NUM_PRIORITIES_DEF) begin
          prio_q_m[q] = it.val;
          counted = 1'b1;
        end
      end
      REQ_L4S_QUEUE: begin
        if (it.idx < PORT_COUNT_DEF) begin
          l4s_util_m[it.idx] = it.val;
          counted = 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ports cluster on a few entries so updates and packets meet
  function automatic logic [PORT_W-1:0] pick_port();
    if ($urandom_range(9) < 6) return PORT_W'($urandom_range(3));
    return PORT_W'($urandom_range(IDX_MAX));
  endfunction

  function automatic adm_req_t rand_item();
    adm_req_t it;
    int       sel;
    int       v;
    it.req  = REQ_PACKET;
    it.ecn  = ECN_W'($urandom_range(3));
    it.port = pick_port();
    it.prio = PRIO_W'($urandom_range(NUM_PRIORITIES_DEF - 1));
    it.tag  = $urandom;
    it.idx  = pick_port();
    v = int'(thr_m) - 2 + int'($urandom_range(3));
    if (v < 0) v = 0;
    if (v > UTIL_MAX) v = UTIL_MAX;
    it.val = ($urandom_range(9) < 4) ? UTIL_W'(v) : UTIL_W'($urandom_range(UTIL_MAX));
    sel = $urandom_range(99);
    if (sel < 45) it.req = REQ_PACKET;
    else if (sel < 57) begin
      it.req = REQ_MEM_GROUP;
      it.idx = ($urandom_range(9) < 8) ? IDX_W'($urandom_range(NUM_MEM_GROUPS_DEF - 1))
                                       : IDX_W'($urandom_range(IDX_MAX, NUM_MEM_GROUPS_DEF));
    end
    else if (sel < 69) it.req = REQ_PORT_GROUP;
    else if (sel < 81) it.req = REQ_PRIO_QUEUE;
    else if (sel < 93) it.req = REQ_L4S_QUEUE;
    else it.req = REQ_W'($urandom_range(REQ_RSVD_7, REQ_RSVD_5));
    return it;
  endfunction

  task automatic push_item(input adm_req_t it, input logic typed,
                           input logic [ACT_W-1:0] act, input logic [UTIL_W-1:0] util,
                           output bit counted);
    verdict_t v;
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.req;
    in_tdata  <= {{(IN_DATA_W-57){1'b0}}, it.val, it.idx, it.tag, it.prio, it.port, it.ecn};
    do @(posedge clk); while (!in_tready);
    if (admit_model(it, v, counted)) begin
      if (typed) begin
        v.act  = act;
        v.util = util;
      end
      pending_verdicts.push_back(v);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= a;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    if (a == CFG_THRESHOLD) thr_m = d[UTIL_W-1:0];
    else if (a == CFG_GROUP_MAP) gmap_m = d[MAP_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  wire [PORT_W-1:0] got_port = out_tdata[PORT_W-1:0];
  wire [TAG_W-1:0]  got_tag  = out_tdata[PORT_W +: TAG_W];
  wire [UTIL_W-1:0] got_util = out_tdata[PORT_W+TAG_W +: UTIL_W];
  verdict_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no item pending: port %0d tag %h", got_port, got_tag);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tuser !== want.act) begin
          $error("action: expected %0d, got %0d", want.act, out_tuser);
          errors++;
        end
        if (got_port !== want.port) begin
          $error("out_port: expected %0d, got %0d", want.port, got_port);
          errors++;
        end
        if (got_tag !== want.tag) begin
          $error("out_tag: expected %h, got %h", want.tag, got_tag);
          errors++;
        end
        if (got_util !== want.util) begin
          $error("checked_utilization: expected %0d, got %0d", want.util, got_util);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    adm_req_t it;
    bit       counted;
    int       done_items;
    int       quota;
    logic [UTIL_W-1:0] thr_v;
    logic [MAP_W-1:0]  map_v;

    foreach (grp_util_m[i]) grp_util_m[i] = '0;
    foreach (port_grp_m[i]) port_grp_m[i] = '0;
    foreach (prio_q_m[i]) prio_q_m[i] = '0;
    foreach (l4s_util_m[i]) l4s_util_m[i] = '0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_DIRECTED; r++)
      push_item(dir_tbl[r].it, dir_tbl[r].typed, dir_tbl[r].act, dir_tbl[r].util, counted);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      thr_v = UTIL_W'($urandom_range(160, 90));
      map_v = MAP_W'($urandom);
      quota = 300;
      case (ph)
        0: begin
          thr_v = '0;
          map_v = '1;
          quota = 150;
        end
        1: thr_v = '1;
        3: map_v = '0;
        4: thr_v = UTIL_W'(1);
        5: quota = 400;
        default: ;
      endcase
      cfg_write(CFG_THRESHOLD, CFG_DATA_W'(thr_v));
      cfg_write(CFG_GROUP_MAP, CFG_DATA_W'(map_v));
      if (ph < 2) begin
        snd_idle_pct = 9;
        rcv_idle_pct = 65;
      end else if (ph < 4) begin
        snd_idle_pct = 65;
        rcv_idle_pct = 9;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // long result-side hold while items keep coming
      if (ph == 4) hold_req = 1'b1;
      done_items = 0;
      while (done_items < quota) begin
        it = rand_item();
        push_item(it, 1'b0, ACT_CLASSIC, '0, counted);
        if (counted) done_items++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dqua_pkg.sv
hw/rtl/dqua_ram.sv
hw/rtl/dqua_lookup.sv
hw/rtl/dqua_decide.sv
hw/rtl/dualq_utilization_admission_core.sv
sim/tb_dualq_utilization_admission_core.sv
